>>> rtl/rstoi_pkg.sv
// Shared types, codes and tables of the radix string to integer converter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rstoi_pkg;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 32;
  localparam int ACC_W   = 33;
  localparam int SUM_W   = 37;
  localparam int COUNT_W = 6;
  localparam int CFG_W   = 3;

  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_DEC = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [2:0] TYPE_BYTE   = 3'd0;
  localparam logic [2:0] TYPE_SSHORT = 3'd1;
  localparam logic [2:0] TYPE_USHORT = 3'd2;
  localparam logic [2:0] TYPE_SLONG  = 3'd3;
  localparam logic [2:0] TYPE_ULONG  = 3'd4;

  localparam logic [1:0] RADIX_RESET = RADIX_DEC;
  localparam logic [2:0] TYPE_RESET  = TYPE_SLONG;

  localparam logic CFG_RADIX = 1'b0;
  localparam logic CFG_TYPE  = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic       zero;
    logic       blank;
    logic       plus;
    logic       minus;
    logic       dec;
    logic       hex_letter;
    logic [3:0] dval;
    logic       last;
  } char_class_t;

  function automatic logic [COUNT_W-1:0] digit_limit(input logic [1:0] radix,
                                                     input logic [2:0] ttype);
    logic wide;
    logic narrow;
    wide   = (ttype == TYPE_SLONG) || (ttype == TYPE_ULONG);
    narrow = (ttype == TYPE_BYTE);
    unique case (radix)
      RADIX_BIN: digit_limit = narrow ? 6'd8 : (wide ? 6'd32 : 6'd16);
      RADIX_OCT: digit_limit = narrow ? 6'd3 : (wide ? 6'd9 : 6'd6);
      RADIX_DEC: digit_limit = narrow ? 6'd3 : (wide ? 6'd10 : 6'd5);
      RADIX_HEX: digit_limit = narrow ? 6'd2 : (wide ? 6'd8 : 6'd4);
      default:   digit_limit = '0;
    endcase
  endfunction

  function automatic logic [ACC_W-1:0] type_bound(input logic [2:0] ttype);
    unique case (ttype)
      TYPE_BYTE:   type_bound = 33'd255;
      TYPE_SSHORT: type_bound = 33'd32767;
      TYPE_USHORT: type_bound = 33'd65535;
      TYPE_SLONG:  type_bound = 33'd2147483647;
      TYPE_ULONG:  type_bound = 33'd4294967295;
      default:     type_bound = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> rtl/rstoi_in_if.sv
// Input channel of the converter: one character and its end-of-string mark.
// Depends on rstoi_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rstoi_in_if
  import rstoi_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source(output valid, output char_code, output last_char, input ready);
  modport sink(input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

>>> rtl/rstoi_out_if.sv
// Result channel of the converter: accept flag and converted value.
// Depends on rstoi_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rstoi_out_if
  import rstoi_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [VALUE_W-1:0] value;

  modport source(output valid, output accepted, output value, input ready);
  modport sink(input valid, input accepted, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/rstoi_front.sv
// Front end: classifies each incoming character into flags and a digit value.
// Depends on rstoi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rstoi_front
  import rstoi_pkg::*;
(
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic              last_char,
  output      char_class_t       cls
);

  logic is_dec;
  logic is_upper;
  logic is_lower;

  always_comb begin
    is_dec   = (char_code >= 8'h30) && (char_code <= 8'h39);
    is_upper = (char_code >= 8'h41) && (char_code <= 8'h46);
    is_lower = (char_code >= 8'h61) && (char_code <= 8'h66);
    cls.zero       = (char_code == '0);
    cls.blank      = (char_code == CHAR_SPACE) || ((char_code >= 8'd9) && (char_code <= 8'd13));
    cls.plus       = (char_code == CHAR_PLUS);
    cls.minus      = (char_code == CHAR_MINUS);
    cls.dec        = is_dec;
    cls.hex_letter = is_upper || is_lower;
    cls.last       = last_char;
    if (is_dec) begin
      cls.dval = char_code[3:0];
    end else begin
      cls.dval = char_code[3:0] + 4'd9;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rstoi_queue.sv
// Short queue of classified characters between the front and back ends.
// Depends on rstoi_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module rstoi_queue
  import rstoi_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire char_class_t push_data,
  output      logic        full,
  input  wire logic        pop,
  output      logic        head_valid,
  output      char_class_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  char_class_t      entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/rstoi_back.sv
// Back end: scan state machine, digit accumulator with bound check, and the
// result register. Depends on rstoi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rstoi_back
  import rstoi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [1:0]  source_radix,
  input  wire logic [2:0]  target_type,
  input  wire logic        head_valid,
  input  wire char_class_t head,
  output      logic        pop,
  rstoi_out_if.source      out_ch
);

  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_PLUS  = 3'd1;
  localparam logic [2:0] PH_DIGIT = 3'd2;
  localparam logic [2:0] PH_TRAIL = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;

  logic [2:0]         phase;
  logic [ACC_W-1:0]   acc;
  logic [COUNT_W-1:0] count;
  logic               neg;
  logic               failed;

  logic [2:0]         phase_next;
  logic [ACC_W-1:0]   acc_next;
  logic [COUNT_W-1:0] count_next;
  logic               neg_next;
  logic               failed_next;

  logic               res_valid;
  logic               res_ok;
  logic               res_neg;
  logic [2:0]         res_type;
  logic [VALUE_W-1:0] res_acc;

  logic               bad_type;
  logic               digit_ok;
  logic               minus_ok;
  logic [SUM_W-1:0]   scaled;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   limit_val;
  logic [2:0]         ph;
  logic               stop;
  logic               ok_next;
  logic [VALUE_W-1:0] signed_val;

  assign pop = head_valid && (!head.last || !res_valid || out_ch.ready);

  always_comb begin
    bad_type = (target_type > TYPE_ULONG);
    minus_ok = (source_radix == RADIX_DEC) &&
               ((target_type == TYPE_SSHORT) || (target_type == TYPE_SLONG));
    if (source_radix == RADIX_HEX) begin
      digit_ok = head.dec || head.hex_letter;
    end else begin
      unique case (source_radix)
        RADIX_BIN: digit_ok = head.dec && (head.dval < 4'd2);
        RADIX_OCT: digit_ok = head.dec && (head.dval < 4'd8);
        default:   digit_ok = head.dec;
      endcase
    end
    unique case (source_radix)
      RADIX_BIN: scaled = {3'b0, acc, 1'b0};
      RADIX_OCT: scaled = {1'b0, acc, 3'b0};
      RADIX_DEC: scaled = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0};
      default:   scaled = {acc, 4'b0};
    endcase
    sum       = scaled + SUM_W'(head.dval);
    limit_val = SUM_W'(type_bound(target_type)) + SUM_W'(neg);

    phase_next  = phase;
    acc_next    = acc;
    count_next  = count;
    neg_next    = neg;
    failed_next = failed;
    ph          = phase;
    stop        = 1'b0;

    if (bad_type) begin
      failed_next = 1'b1;
    end
    if (!failed && !bad_type && (phase != PH_DONE)) begin
      if (head.zero) begin
        phase_next = PH_DONE;
      end else begin
        if (ph == PH_LEAD) begin
          if (head.blank) begin
            stop = 1'b1;
          end else if (head.plus) begin
            phase_next = PH_PLUS;
            stop       = 1'b1;
          end else begin
            ph         = PH_PLUS;
            phase_next = PH_PLUS;
          end
        end
        if (!stop && (ph == PH_PLUS)) begin
          if (head.minus) begin
            if (minus_ok) begin
              neg_next   = 1'b1;
              phase_next = PH_DIGIT;
            end else begin
              failed_next = 1'b1;
            end
            stop = 1'b1;
          end else begin
            ph         = PH_DIGIT;
            phase_next = PH_DIGIT;
          end
        end
        if (!stop && (ph == PH_DIGIT)) begin
          if (digit_ok && (count < digit_limit(source_radix, target_type))) begin
            acc_next   = sum[ACC_W-1:0];
            count_next = count + 1'b1;
            if (sum > limit_val) begin
              failed_next = 1'b1;
            end
            stop = 1'b1;
          end else begin
            phase_next = PH_TRAIL;
          end
        end
        if (!stop && !head.blank) begin
          failed_next = 1'b1;
        end
      end
    end
    ok_next = !failed_next && (count_next != '0) && !bad_type;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_LEAD;
      acc    <= '0;
      count  <= '0;
      neg    <= 1'b0;
      failed <= 1'b0;
    end else if (pop) begin
      if (head.last) begin
        phase  <= PH_LEAD;
        acc    <= '0;
        count  <= '0;
        neg    <= 1'b0;
        failed <= 1'b0;
      end else begin
        phase  <= phase_next;
        acc    <= acc_next;
        count  <= count_next;
        neg    <= neg_next;
        failed <= failed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && head.last) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      res_ok   <= ok_next;
      res_neg  <= neg_next;
      res_type <= target_type;
      res_acc  <= acc_next[VALUE_W-1:0];
    end
  end

  always_comb begin
    signed_val = res_neg ? (~res_acc + 1'b1) : res_acc;
    if (!res_ok) begin
      out_ch.value = '0;
    end else begin
      priority if (res_type == TYPE_BYTE) begin
        out_ch.value = {24'b0, signed_val[7:0]};
      end else if ((res_type == TYPE_SSHORT) || (res_type == TYPE_USHORT)) begin
        out_ch.value = {16'b0, signed_val[15:0]};
      end else begin
        out_ch.value = signed_val;
      end
    end
  end

  assign out_ch.valid    = res_valid;
  assign out_ch.accepted = res_ok;

endmodule

`default_nettype wire

>>> rtl/radix_string_to_integer_top.sv
// Top level of the radix string to integer converter: configuration registers,
// front end, queue and back end. Depends on rstoi_pkg, the channel interfaces
// and the rstoi_front, rstoi_queue and rstoi_back modules.
//
// Usage:
//   in_ch carries one character per transfer with last_char marking the end
//   of a string; out_ch carries one result (accepted, value) per string, on
//   the transfer of its last character. Configuration (index 0 radix, index 1
//   target type) is written through cfg_we / cfg_index / cfg_data while idle.
//   Throughput: one character per cycle while no result waits on a low
//   out_ch.ready, set by the single accumulate and bound check done per
//   character in the back end. Result path: the last character is written
//   into the queue, then popped and scanned straight into the result
//   register, which drives out_ch.
//   Reset: rst clears the scan state and the queue and restores radix decimal
//   and target signed long.
//   Stall: while out_ch.ready is low and a result waits, the back end keeps
//   scanning characters of the next string and halts only at its last one;
//   the queue then fills and in_ch.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module radix_string_to_integer_top
  import rstoi_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  rstoi_in_if.sink              in_ch,
  rstoi_out_if.source           out_ch
);

  logic [1:0]  source_radix;
  logic [2:0]  target_type;
  char_class_t cls;
  char_class_t head;
  logic        q_full;
  logic        head_valid;
  logic        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_radix <= RADIX_RESET;
      target_type  <= TYPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIX: source_radix <= cfg_data[1:0];
        CFG_TYPE:  target_type  <= cfg_data;
        default:   ;
      endcase
    end
  end

  assign in_ch.ready = !q_full;

  rstoi_front u_front (
    .char_code (in_ch.char_code),
    .last_char (in_ch.last_char),
    .cls       (cls)
  );

  rstoi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_ch.valid),
    .push_data  (cls),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  rstoi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .source_radix (source_radix),
    .target_type  (target_type),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire

>>> dv/tb_radix_string_to_integer_top.sv
// Self-checking testbench for radix_string_to_integer_top: directed and random strings
// in every radix and target type, predicted per character and checked per result.
// Depends on rstoi_pkg, rstoi_in_if, rstoi_out_if and the converter RTL.
`timescale 1ns / 1ps

module tb_radix_string_to_integer_top;
  import rstoi_pkg::*;

  localparam int RANDOM_CHARS  = 1350;
  localparam int CALM_CHARS    = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 10;

  localparam logic [2:0] TYPE_UNKNOWN = 3'd7;

  typedef enum logic [2:0] {
    SCAN_LEAD,
    SCAN_SIGN,
    SCAN_DIGITS,
    SCAN_TRAIL,
    SCAN_DONE
  } scan_phase_t;

  typedef struct packed {
    logic               accepted;
    logic [VALUE_W-1:0] value;
  } conversion_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  rstoi_in_if  in_ch();
  rstoi_out_if out_ch();

  radix_string_to_integer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #4 clk = ~clk;

  // Register mirror and scan state of the predictor
  logic [1:0]         radix_sel   = RADIX_RESET;
  logic [2:0]         type_sel    = TYPE_RESET;
  scan_phase_t        scan_state  = SCAN_LEAD;
  logic [SUM_W-1:0]   magnitude   = '0;
  logic [COUNT_W-1:0] digits_seen = '0;
  logic               minus_seen  = 1'b0;
  logic               scan_failed = 1'b0;

  logic [5:0] digit_cap [20] = '{
    6'd8, 6'd16, 6'd16, 6'd32, 6'd32,
    6'd3, 6'd6,  6'd6,  6'd9,  6'd9,
    6'd3, 6'd5,  6'd5,  6'd10, 6'd10,
    6'd2, 6'd4,  6'd4,  6'd8,  6'd8
  };
  logic [ACC_W-1:0] value_cap [5] = '{
    33'd255, 33'd32767, 33'd65535, 33'd2147483647, 33'd4294967295
  };

  conversion_t expected_results[$];
  logic [7:0]  text_buf[$];
  int          fail_count  = 0;
  int          chars_sent  = 0;
  int          cycle_count = 0;
  bit          src_idle    = 1'b1;
  bit          snk_idle    = 1'b1;

  function automatic logic [4:0] base_of(logic [1:0] r);
    case (r)
      RADIX_BIN: return 5'd2;
      RADIX_OCT: return 5'd8;
      RADIX_DEC: return 5'd10;
      default:   return 5'd16;
    endcase
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CHAR_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void scan_character(logic [7:0] c);
    logic [4:0] base;
    logic [4:0] d;
    base = base_of(radix_sel);
    if (type_sel > TYPE_ULONG) scan_failed = 1'b1;
    if (scan_failed || scan_state == SCAN_DONE) return;
    if (c == 8'd0) begin
      scan_state = SCAN_DONE;
      return;
    end
    if (scan_state == SCAN_LEAD) begin
      if (is_blank(c)) return;
      scan_state = SCAN_SIGN;
      if (c == CHAR_PLUS) return;
    end
    if (scan_state == SCAN_SIGN) begin
      if (c == CHAR_MINUS) begin
        if (radix_sel == RADIX_DEC && (type_sel == TYPE_SSHORT || type_sel == TYPE_SLONG)) begin
          minus_seen = 1'b1;
          scan_state = SCAN_DIGITS;
        end else begin
          scan_failed = 1'b1;
        end
        return;
      end
      scan_state = SCAN_DIGITS;
    end
    if (scan_state == SCAN_DIGITS) begin
      if (c >= "0" && c <= "9") d = 5'(c - "0");
      else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
      else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd16);
      else d = 5'd22;
      if (base == 5'd16 && d > 5'd15) d = d - 5'd6;
      if (d < base && digits_seen < digit_cap[int'(radix_sel) * 5 + int'(type_sel)]) begin
        magnitude = magnitude * base + d;
        if (magnitude > value_cap[type_sel] + minus_seen) scan_failed = 1'b1;
        digits_seen = digits_seen + 1'b1;
        return;
      end
      scan_state = SCAN_TRAIL;
    end
    if (!is_blank(c)) scan_failed = 1'b1;
  endfunction

  function automatic void finish_string();
    conversion_t      r;
    logic [SUM_W-1:0] twos;
    r.accepted = !scan_failed && digits_seen != 0 && type_sel <= TYPE_ULONG;
    r.value    = '0;
    if (r.accepted) begin
      twos = minus_seen ? -magnitude : magnitude;
      case (type_sel)
        TYPE_BYTE:                r.value = {24'd0, twos[7:0]};
        TYPE_SSHORT, TYPE_USHORT: r.value = {16'd0, twos[15:0]};
        default:                  r.value = twos[31:0];
      endcase
    end
    expected_results.push_back(r);
    scan_state  = SCAN_LEAD;
    magnitude   = '0;
    digits_seen = '0;
    minus_seen  = 1'b0;
    scan_failed = 1'b0;
  endfunction

  function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] digit_char(logic [4:0] d);
    if (d < 5'd10) return "0" + 8'(d);
    return ($urandom_range(0, 1) ? "A" : "a") + 8'(d - 5'd10);
  endfunction

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CHAR_SPACE : 8'(9 + k);
  endfunction

  // Fill text_buf with one string: mostly a well-formed number, sometimes noise
  function automatic void make_string();
    logic [4:0]       base;
    logic [SUM_W-1:0] v;
    logic [7:0]       digs[$];
    int               limit;
    int               ndig;
    int               mode;
    int               capi;
    bit               neg_ok;
    bit               neg;
    base  = base_of(radix_sel);
    capi  = (type_sel <= TYPE_ULONG) ? int'(type_sel) : 4;
    limit = (type_sel <= TYPE_ULONG) ? int'(digit_cap[int'(radix_sel) * 5 + capi]) : 4;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) text_buf.push_back(blank_char());
    if ($urandom_range(0, 4) == 0) text_buf.push_back(CHAR_PLUS);
    neg_ok = radix_sel == RADIX_DEC && (type_sel == TYPE_SSHORT || type_sel == TYPE_SLONG);
    neg = neg_ok ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 19) == 0);
    if (neg) text_buf.push_back(CHAR_MINUS);
    mode = $urandom_range(0, 3);
    v = '0;
    case (mode)
      0: begin
        ndig = $urandom_range(1, limit);
        if ($urandom_range(0, 7) == 0) ndig++;
        repeat (ndig) digs.push_back(digit_char(5'($urandom_range(0, base - 1))));
      end
      1: v = value_cap[capi] + neg + $urandom_range(0, 5) - 3;
      2: v = $urandom_range(0, 20);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if (mode != 0) begin
      do begin
        digs.push_front(digit_char(5'(v % base)));
        v = v / base;
      end while (v != 0);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) digs.push_front("0");
    end
    foreach (digs[i]) text_buf.push_back(digs[i]);
    repeat ($urandom_range(0, 2)) text_buf.push_back(blank_char());
    if ($urandom_range(0, 14) == 0)
      text_buf.insert($urandom_range(0, text_buf.size()), 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 14) == 0) begin
      text_buf.push_back(8'd0);
      repeat ($urandom_range(0, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_char(logic [7:0] c, logic last);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.last_char <= last;
    do @(posedge clk); while (!in_ch.ready);
    chars_sent++;
    scan_character(c);
    if (last) finish_string();
  endtask

  task automatic send_text(bit close);
    for (int i = 0; i < text_buf.size(); i++)
      send_char(text_buf[i], close && i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  // Hold the sender until every result is in, then let the pipeline drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RADIX) radix_sel = data[1:0];
    else type_sel = data;
    @(posedge clk);
  endtask

  task automatic configure(logic [1:0] r, logic [2:0] t);
    write_reg(CFG_RADIX, {1'($urandom_range(0, 1)), r});
    write_reg(CFG_TYPE, t);
  endtask

  task automatic send_number(string s);
    add_text(s);
    send_text(1'b1);
  endtask

  task automatic test_reset_defaults();
    send_number("-2147483648");
    send_number("2147483648");
    send_number(" \t+7 \r");
    settle();
  endtask

  task automatic test_type_extremes();
    configure(RADIX_HEX, TYPE_ULONG);
    send_number("fFfFfFfF");
    configure(RADIX_BIN, TYPE_BYTE);
    send_number("11111111");
    send_number("100000000");
    configure(RADIX_OCT, TYPE_USHORT);
    send_number("177777");
    send_number("-1");
    configure(RADIX_DEC, TYPE_SSHORT);
    send_number("-32768");
    send_number("32768");
    configure(RADIX_DEC, TYPE_BYTE);
    send_number("256");
    settle();
  endtask

  task automatic test_special_cases();
    configure(RADIX_DEC, TYPE_SLONG);
    send_number(" +");
    send_number("1 2");
    add_text("12");
    text_buf.push_back(8'd0);
    add_text("x9");
    send_text(1'b1);
    settle();
    write_reg(CFG_TYPE, TYPE_UNKNOWN);
    send_number("5");
    settle();
    // change radix in the middle of a string
    write_reg(CFG_TYPE, TYPE_SLONG);
    add_text("12");
    send_text(1'b0);
    settle();
    write_reg(CFG_RADIX, {1'b0, RADIX_HEX});
    send_number("F");
    settle();
  endtask

  task automatic test_random_strings(int quota, bit calm);
    int start;
    start = chars_sent;
    while (chars_sent - start < quota) begin
      settle();
      configure(2'($urandom_range(0, 3)),
                ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4)));
      src_idle = !calm && $urandom_range(0, 2) != 0;
      snk_idle = !calm && $urandom_range(0, 2) != 0;
      repeat ($urandom_range(8, 25)) begin
        if (chars_sent - start < quota) begin
          make_string();
          send_text(1'b1);
        end
      end
    end
  endtask

  // Result side: random stall bursts while snk_idle is set
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (snk_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    conversion_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0, out_ch.value);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.accepted !== want.accepted)
          report_mismatch("accepted", 32'(want.accepted), 32'(out_ch.accepted));
        if (out_ch.value !== want.value)
          report_mismatch("value", want.value, out_ch.value);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout, %0d results outstanding", expected_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_RADIX;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= '0;
    in_ch.last_char <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_type_extremes();
    test_special_cases();
    test_random_strings(RANDOM_CHARS - CALM_CHARS, 1'b0);
    test_random_strings(CALM_CHARS, 1'b1);
    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
